### hw/rtl/tptz_pkg.sv
// Shared types, widths and codes for the three-pole three-zero compensator.
// No dependencies; used by every module of the block.
package tptz_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int LIMIT_WIDTH    = 16;
  localparam int CFG_DATA_WIDTH = 2 * LIMIT_WIDTH;
  localparam int CFG_IDX_WIDTH  = 4;

  // error is one bit wider than a sample so ref - fb never wraps
  localparam int ERR_WIDTH   = SAMPLE_WIDTH + 1;
  localparam int PROD_E_WIDTH = COEF_WIDTH + ERR_WIDTH;
  localparam int PROD_U_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
  // seven terms: three guard bits over the widest product
  localparam int ACC_WIDTH   = PROD_E_WIDTH + 3;
  localparam int SHIFT_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;

  localparam int HIST_DEPTH = 3;

  // register map
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_B0 = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_B1 = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_B2 = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_B3 = CFG_IDX_WIDTH'(3);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_A1 = CFG_IDX_WIDTH'(4);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_A2 = CFG_IDX_WIDTH'(5);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COEF_A3 = CFG_IDX_WIDTH'(6);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LIMITS  = CFG_IDX_WIDTH'(7);

  localparam logic [CFG_DATA_WIDTH-1:0] LIMITS_RESET = 32'h7FFF_8000;

  typedef enum logic [1:0] {
    LIM_NONE = 2'd0,
    LIM_MAX  = 2'd1,
    LIM_MIN  = 2'd2
  } limit_code_t;

  typedef struct packed {
    logic [COEF_WIDTH-1:0] b0;
    logic [COEF_WIDTH-1:0] b1;
    logic [COEF_WIDTH-1:0] b2;
    logic [COEF_WIDTH-1:0] b3;
    logic [COEF_WIDTH-1:0] a1;
    logic [COEF_WIDTH-1:0] a2;
    logic [COEF_WIDTH-1:0] a3;
    logic [LIMIT_WIDTH-1:0] lim_max;
    logic [LIMIT_WIDTH-1:0] lim_min;
  } comp_cfg_t;

endpackage

### hw/rtl/tptz_regs.sv
// Configuration register file: coefficients and output limits.
// Depends on tptz_pkg.
module tptz_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [tptz_pkg::CFG_IDX_WIDTH-1:0]  wr_index,
  input  logic [tptz_pkg::CFG_DATA_WIDTH-1:0] wr_data,
  output tptz_pkg::comp_cfg_t                 cfg
);

  tptz_pkg::comp_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.b0      <= '0;
      regs.b1      <= '0;
      regs.b2      <= '0;
      regs.b3      <= '0;
      regs.a1      <= '0;
      regs.a2      <= '0;
      regs.a3      <= '0;
      regs.lim_max <= tptz_pkg::LIMITS_RESET[tptz_pkg::CFG_DATA_WIDTH-1:tptz_pkg::LIMIT_WIDTH];
      regs.lim_min <= tptz_pkg::LIMITS_RESET[tptz_pkg::LIMIT_WIDTH-1:0];
    end else if (wr_en) begin
      unique case (wr_index)
        tptz_pkg::REG_COEF_B0: regs.b0 <= wr_data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_B1: regs.b1 <= wr_data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_B2: regs.b2 <= wr_data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_B3: regs.b3 <= wr_data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_A1: regs.a1 <= wr_data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_A2: regs.a2 <= wr_data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_A3: regs.a3 <= wr_data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_LIMITS: begin
          regs.lim_max <= wr_data[tptz_pkg::CFG_DATA_WIDTH-1:tptz_pkg::LIMIT_WIDTH];
          regs.lim_min <= wr_data[tptz_pkg::LIMIT_WIDTH-1:0];
        end
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule

### hw/rtl/tptz_datapath.sv
// Control law datapath: error, seven products, sum, shift, clamp, and the
// error/output history taps. Depends on tptz_pkg.
module tptz_datapath (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      step,
  input  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]  reference,
  input  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]  feedback,
  input  tptz_pkg::comp_cfg_t                       cfg,
  output logic        [tptz_pkg::SAMPLE_WIDTH-1:0]  drive_next,
  output tptz_pkg::limit_code_t                     limited_next
);

  logic signed [tptz_pkg::ERR_WIDTH-1:0]    err_hist [tptz_pkg::HIST_DEPTH];
  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] out_hist [tptz_pkg::HIST_DEPTH];

  logic signed [tptz_pkg::ERR_WIDTH-1:0]    err;
  logic signed [tptz_pkg::COEF_WIDTH-1:0]   b0, b1, b2, b3, a1, a2, a3;
  logic signed [tptz_pkg::PROD_E_WIDTH-1:0] pb0, pb1, pb2, pb3;
  logic signed [tptz_pkg::PROD_U_WIDTH-1:0] pa1, pa2, pa3;
  logic signed [tptz_pkg::ACC_WIDTH-1:0]    acc;
  logic signed [tptz_pkg::SHIFT_WIDTH-1:0]  u_raw;
  logic signed [tptz_pkg::LIMIT_WIDTH-1:0]  lim_hi, lim_lo;
  logic signed [tptz_pkg::SHIFT_WIDTH-1:0]  u_clamped;

  assign err = tptz_pkg::ERR_WIDTH'(reference) - tptz_pkg::ERR_WIDTH'(feedback);

  assign b0 = $signed(cfg.b0);
  assign b1 = $signed(cfg.b1);
  assign b2 = $signed(cfg.b2);
  assign b3 = $signed(cfg.b3);
  assign a1 = $signed(cfg.a1);
  assign a2 = $signed(cfg.a2);
  assign a3 = $signed(cfg.a3);

  // products are full width, operands sign-extended by context
  assign pb0 = b0 * err;
  assign pb1 = b1 * err_hist[0];
  assign pb2 = b2 * err_hist[1];
  assign pb3 = b3 * err_hist[2];
  assign pa1 = a1 * out_hist[0];
  assign pa2 = a2 * out_hist[1];
  assign pa3 = a3 * out_hist[2];

  assign acc = tptz_pkg::ACC_WIDTH'(pb0) + tptz_pkg::ACC_WIDTH'(pb1)
             + tptz_pkg::ACC_WIDTH'(pb2) + tptz_pkg::ACC_WIDTH'(pb3)
             + tptz_pkg::ACC_WIDTH'(pa1) + tptz_pkg::ACC_WIDTH'(pa2)
             + tptz_pkg::ACC_WIDTH'(pa3);

  // arithmetic shift right by the fraction bits: drop the low bits
  assign u_raw = acc[tptz_pkg::ACC_WIDTH-1:tptz_pkg::COEF_FRAC_BITS];

  assign lim_hi = $signed(cfg.lim_max);
  assign lim_lo = $signed(cfg.lim_min);

  // max test first, so with inverted limits a value above max clamps to max
  always_comb begin
    priority if (u_raw > tptz_pkg::SHIFT_WIDTH'(lim_hi)) begin
      u_clamped    = tptz_pkg::SHIFT_WIDTH'(lim_hi);
      limited_next = tptz_pkg::LIM_MAX;
    end else if (u_raw < tptz_pkg::SHIFT_WIDTH'(lim_lo)) begin
      u_clamped    = tptz_pkg::SHIFT_WIDTH'(lim_lo);
      limited_next = tptz_pkg::LIM_MIN;
    end else begin
      u_clamped    = u_raw;
      limited_next = tptz_pkg::LIM_NONE;
    end
  end

  assign drive_next = u_clamped[tptz_pkg::SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tptz_pkg::HIST_DEPTH; i++) begin
        err_hist[i] <= '0;
        out_hist[i] <= '0;
      end
    end else if (step) begin
      err_hist[0] <= err;
      out_hist[0] <= $signed(drive_next);
      for (int i = 1; i < tptz_pkg::HIST_DEPTH; i++) begin
        err_hist[i] <= err_hist[i-1];
        out_hist[i] <= out_hist[i-1];
      end
    end
  end

endmodule

### hw/rtl/three_pole_three_zero_compensator_core.sv
// Three-pole three-zero compensator core, order-3 IIR control law.
// An accepted sample beat waits in the input stage; its result then waits in the result register.
// Throughput: one sample beat per cycle, sustained while results are taken.
// Critical path: seven parallel multipliers, the adder tree and the clamp.
// Synchronous reset clears the coefficients, loads limits 0x7FFF8000,
// zeroes both history lines and empties the input and result stages.
module three_pole_three_zero_compensator_core (
  input  logic                                      clk,
  input  logic                                      rst,
  // sample channel
  input  logic                                      sample_valid,
  output logic                                      sample_ready,
  input  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]  reference,
  input  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]  feedback,
  // result channel
  output logic                                      result_valid,
  input  logic                                      result_ready,
  output logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]  drive,
  output logic        [1:0]                         limited,
  // configuration write channel
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic        [tptz_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic        [tptz_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

  tptz_pkg::comp_cfg_t cfg;

  // input stage: one sample beat waiting for the datapath
  logic                                     in_valid;
  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] ref_q;
  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] fb_q;

  // a step consumes the input stage and fills the result register
  logic                                     step;
  logic        [tptz_pkg::SAMPLE_WIDTH-1:0] drive_next;
  tptz_pkg::limit_code_t                    limited_next;

  // register writes take effect at once; the port never stalls
  assign cfg_ready = 1'b1;

  tptz_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register is free if empty or being drained this cycle.
  assign step         = in_valid && (!result_valid || result_ready);
  // The input stage can take a beat while a finished result still waits.
  assign sample_ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample_ready) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      ref_q <= reference;
      fb_q  <= feedback;
    end
  end

  tptz_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .reference    (ref_q),
    .feedback     (fb_q),
    .cfg          (cfg),
    .drive_next   (drive_next),
    .limited_next (limited_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive   <= $signed(drive_next);
      limited <= limited_next;
    end
  end

endmodule

### dv/tb_three_pole_three_zero_compensator_core.sv
// Self-checking testbench for three_pole_three_zero_compensator_core.
// Depends on tptz_pkg and the core RTL; a scoreboard class predicts each drive beat.
module tb_three_pole_three_zero_compensator_core;

  // run-length guard: far above the slowest legal run (~800 beats)
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS = 75;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] drive;
    tptz_pkg::limit_code_t                    lim;
  } drive_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the register file and both history lines, predicts
  // the clamped control output for every accepted sample beat.
  // --------------------------------------------------------------------------
  class compensator_scoreboard;
    logic signed [tptz_pkg::COEF_WIDTH-1:0]   coef_b [4];
    logic signed [tptz_pkg::COEF_WIDTH-1:0]   coef_a [4];   // index 0 unused
    logic signed [tptz_pkg::LIMIT_WIDTH-1:0]  lim_max;
    logic signed [tptz_pkg::LIMIT_WIDTH-1:0]  lim_min;
    logic signed [tptz_pkg::ERR_WIDTH-1:0]    err_hist [tptz_pkg::HIST_DEPTH];
    logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] out_hist [tptz_pkg::HIST_DEPTH];
    drive_beat_t                              expected_drives [$];
    int                                       mismatches;
    int                                       results_seen;

    function new();
      for (int i = 0; i < 4; i++) begin
        coef_b[i] = '0;
        coef_a[i] = '0;
      end
      lim_max = tptz_pkg::LIMITS_RESET[31:16];
      lim_min = tptz_pkg::LIMITS_RESET[15:0];
      for (int i = 0; i < tptz_pkg::HIST_DEPTH; i++) begin
        err_hist[i] = '0;
        out_hist[i] = '0;
      end
      mismatches = 0;
      results_seen = 0;
    endfunction

    // coefficients keep only their low 24 bits; unknown indexes are dropped
    function void load_reg(logic [tptz_pkg::CFG_IDX_WIDTH-1:0] idx,
                           logic [tptz_pkg::CFG_DATA_WIDTH-1:0] data);
      case (idx)
        tptz_pkg::REG_COEF_B0: coef_b[0] = data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_B1: coef_b[1] = data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_B2: coef_b[2] = data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_B3: coef_b[3] = data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_A1: coef_a[1] = data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_A2: coef_a[2] = data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_COEF_A3: coef_a[3] = data[tptz_pkg::COEF_WIDTH-1:0];
        tptz_pkg::REG_LIMITS: begin
          lim_max = data[31:16];
          lim_min = data[15:0];
        end
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] r,
                              logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] f);
      logic signed [tptz_pkg::ERR_WIDTH-1:0] err;
      longint      acc;
      longint      u;
      drive_beat_t beat;
      err = tptz_pkg::ERR_WIDTH'(longint'(r) - longint'(f));
      acc = longint'(coef_b[0]) * longint'(err);
      for (int i = 0; i < tptz_pkg::HIST_DEPTH; i++) begin
        acc += longint'(coef_b[i+1]) * longint'(err_hist[i]);
        acc += longint'(coef_a[i+1]) * longint'(out_hist[i]);
      end
      u = acc >>> tptz_pkg::COEF_FRAC_BITS;
      // max test first, so inverted limits resolve the same way as the RTL
      if (u > longint'(lim_max)) begin
        u = longint'(lim_max);
        beat.lim = tptz_pkg::LIM_MAX;
      end else if (u < longint'(lim_min)) begin
        u = longint'(lim_min);
        beat.lim = tptz_pkg::LIM_MIN;
      end else begin
        beat.lim = tptz_pkg::LIM_NONE;
      end
      beat.drive = tptz_pkg::SAMPLE_WIDTH'(u);
      for (int i = tptz_pkg::HIST_DEPTH - 1; i > 0; i--) begin
        err_hist[i] = err_hist[i-1];
        out_hist[i] = out_hist[i-1];
      end
      err_hist[0] = err;
      out_hist[0] = beat.drive;
      expected_drives.push_back(beat);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("error: result beat %0d: %s", results_seen, what);
    endtask

    task check_result(logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] d, logic [1:0] l);
      drive_beat_t beat;
      if (expected_drives.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        beat = expected_drives.pop_front();
        if (d !== beat.drive)
          report_mismatch($sformatf("drive %0d, expected %0d", d, beat.drive));
        if (l !== beat.lim)
          report_mismatch($sformatf("limited %0d, expected %0d", l, beat.lim));
      end
      results_seen++;
    endtask

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                                       clk;
  logic                                       rst;
  logic                                       sample_valid;
  logic                                       sample_ready;
  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]   reference;
  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]   feedback;
  logic                                       result_valid;
  logic                                       result_ready;
  logic signed [tptz_pkg::SAMPLE_WIDTH-1:0]   drive;
  logic [1:0]                                 limited;
  logic                                       cfg_valid;
  logic                                       cfg_ready;
  logic [tptz_pkg::CFG_IDX_WIDTH-1:0]         cfg_index;
  logic [tptz_pkg::CFG_DATA_WIDTH-1:0]        cfg_data;

  three_pole_three_zero_compensator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .reference    (reference),
    .feedback     (feedback),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .drive        (drive),
    .limited      (limited),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  compensator_scoreboard sb;

  // idling knobs, flipped per phase; hold_request asks the result side
  // for one long stall while the sample side keeps pushing
  bit send_idle;
  bit recv_idle;
  int hold_request = 0;
  int cycle_count = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hard stop if the handshakes ever hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("three_pole_three_zero_compensator_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Everything is driven at the falling edge and sampled at the
  // rising edge. Valid is left high between back-to-back beats.
  // --------------------------------------------------------------------------

  // one config beat; caller drops cfg_valid after the last of a burst
  task automatic write_reg(input logic [tptz_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [tptz_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.load_reg(idx, data);
    @(negedge clk);
  endtask

  // full register set; coefficient upper byte is junk the block must ignore
  task automatic load_setting(input logic [tptz_pkg::COEF_WIDTH-1:0] b0, b1, b2, b3,
                                                                     a1, a2, a3,
                              input logic [tptz_pkg::CFG_DATA_WIDTH-1:0] limits);
    write_reg(tptz_pkg::REG_COEF_B0, {8'($urandom), b0});
    write_reg(tptz_pkg::REG_COEF_B1, {8'($urandom), b1});
    write_reg(tptz_pkg::REG_COEF_B2, {8'($urandom), b2});
    write_reg(tptz_pkg::REG_COEF_B3, {8'($urandom), b3});
    write_reg(tptz_pkg::REG_COEF_A1, {8'($urandom), a1});
    write_reg(tptz_pkg::REG_COEF_A2, {8'($urandom), a2});
    write_reg(tptz_pkg::REG_COEF_A3, {8'($urandom), a3});
    write_reg(tptz_pkg::REG_LIMITS, limits);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] r, f);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    reference    <= r;
    feedback     <= f;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(r, f);
    @(negedge clk);
  endtask

  // result side runs on its own for the whole test
  task automatic take_results();
    int gap;
    bit held;
    held = 1'b0;
    forever begin
      gap = recv_idle ? $urandom_range(0, 9) : 0;
      if (hold_request > 0 && !held) begin
        gap = hold_request;
        held = 1'b1;
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_result(drive, limited);
      @(negedge clk);
    end
  endtask

  // quiet point for register writes; pipeline is 2 deep, leave a few spare
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [tptz_pkg::SAMPLE_WIDTH-1:0] extreme_sample();
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [tptz_pkg::COEF_WIDTH-1:0] extreme_coef();
    case ($urandom_range(0, 4))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return 24'h00_0000;
      3: return 24'h01_0000;   // unity gain
      default: return 24'hFF_FFFF;
    endcase
  endfunction

  // realistic loop gains, full-range junk or corner values, chosen by mode
  task automatic load_random_setting(input int mode);
    logic [tptz_pkg::COEF_WIDTH-1:0]     c [7];
    logic signed [15:0]                  p, q;
    logic [tptz_pkg::CFG_DATA_WIDTH-1:0] limits;
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: c[i] = (i < 4)
                ? tptz_pkg::COEF_WIDTH'($urandom_range(0, 24'h30000) - 24'h18000)
                : tptz_pkg::COEF_WIDTH'($urandom_range(0, 24'h10000) - 24'h8000);
        1: c[i] = tptz_pkg::COEF_WIDTH'($urandom);
        default: c[i] = extreme_coef();
      endcase
    end
    case ($urandom_range(0, 3))
      0: limits = tptz_pkg::LIMITS_RESET;
      1: limits = $urandom;                      // often inverted
      2: begin
        p = 16'($urandom);
        q = 16'($urandom);
        limits = (p > q) ? {p, q} : {q, p};
      end
      default: limits = {extreme_sample(), extreme_sample()};
    endcase
    load_setting(c[0], c[1], c[2], c[3], c[4], c[5], c[6], limits);
  endtask

  task automatic random_sample(output logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] r, f);
    int base;
    case ($urandom_range(0, 3))
      0: begin
        r = 16'($urandom);
        f = 16'($urandom);
      end
      1, 2: begin
        // plant tracking near the setpoint: small error, moderate values
        base = $urandom_range(0, 4000) - 2000;
        r = 16'(base);
        f = 16'(base + $urandom_range(0, 200) - 100);
      end
      default: begin
        r = extreme_sample();
        f = extreme_sample();
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [tptz_pkg::SAMPLE_WIDTH-1:0] r, f;
    sb = new();
    rst          = 1'b1;
    sample_valid = 1'b0;
    reference    = '0;
    feedback     = '0;
    result_ready = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    fork
      take_results();
    join_none

    // reset state: zero coefficients, so any error gives zero drive
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    sample_valid <= 1'b0;
    wait_drained();

    // unity b0: drive follows the error, widest errors hit both rails
    load_setting(24'h01_0000, 24'h00_0000, 24'h00_0000, 24'h00_0000,
                 24'h00_0000, 24'h00_0000, 24'h00_0000, tptz_pkg::LIMITS_RESET);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd100, 16'sd40);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    sample_valid <= 1'b0;
    wait_drained();

    // all coefficients at positive full scale
    load_setting(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF,
                 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, tptz_pkg::LIMITS_RESET);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sd1, 16'sd0);
    sample_valid <= 1'b0;
    wait_drained();

    // all coefficients at negative full scale
    load_setting(24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000,
                 24'h80_0000, 24'h80_0000, 24'h80_0000, tptz_pkg::LIMITS_RESET);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd0, 16'sd1);
    sample_valid <= 1'b0;
    wait_drained();

    // inverted limits: max -100, min +100; max test wins when above max
    load_setting(24'h01_0000, 24'h00_0000, 24'h00_0000, 24'h00_0000,
                 24'h00_0000, 24'h00_0000, 24'h00_0000, 32'hFF9C_0064);
    @(negedge clk);
    // writes to unmapped indexes must not disturb anything
    write_reg(tptz_pkg::CFG_IDX_WIDTH'(8), $urandom);
    write_reg(tptz_pkg::CFG_IDX_WIDTH'(15), $urandom);
    write_reg(tptz_pkg::CFG_IDX_WIDTH'($urandom_range(9, 14)), $urandom);
    cfg_valid <= 1'b0;
    send_sample(-16'sd200, 16'sd0);
    send_sample(16'sd50, 16'sd0);
    send_sample(-16'sd100, 16'sd0);
    sample_valid <= 1'b0;
    wait_drained();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_random_setting(ph % 3);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (ph == 2) begin
        // back-pressure: sender flat out, receiver parked for a long stretch
        send_idle = 1'b0;
        hold_request = HOLD_CYCLES;
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        random_sample(r, f);
        send_sample(r, f);
      end
      sample_valid <= 1'b0;
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("three_pole_three_zero_compensator_core: match");
    end else begin
      $display("three_pole_three_zero_compensator_core: mismatch");
    end
    $finish;
  end

endmodule
